### hw/rtl/assert_macros.svh
// Assertion helpers for the bound checker in mtset_checker.sv.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled during reset.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    `ASSERT_PROP(lbl, (ante) |=> (cons), msg)

`endif

### hw/rtl/mtset_pkg.sv
`default_nettype none
package mtset_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    // stream widths
    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 3;

    localparam int FIELD_W = 16;
    localparam int CODE_W  = 9;
    localparam int VALUE_W = 17;

    typedef enum logic [1:0] {
        ACT_UP     = 2'd0,
        ACT_DOWN   = 2'd1,
        ACT_CHANGE = 2'd2,
        ACT_RSVD   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        EVT_SYN = 2'd0,
        EVT_KEY = 2'd1,
        EVT_ABS = 2'd3
    } evtype_t;

    localparam logic [CODE_W-1:0] CODE_SYN_RPT         = 9'd0;
    localparam logic [CODE_W-1:0] CODE_MT_SLOT         = 9'd47;
    localparam logic [CODE_W-1:0] CODE_MT_TOUCH_MAJOR  = 9'd48;
    localparam logic [CODE_W-1:0] CODE_MT_TOUCH_MINOR  = 9'd49;
    localparam logic [CODE_W-1:0] CODE_MT_POSITION_X   = 9'd53;
    localparam logic [CODE_W-1:0] CODE_MT_POSITION_Y   = 9'd54;
    localparam logic [CODE_W-1:0] CODE_MT_TRACKING_ID  = 9'd57;
    localparam logic [CODE_W-1:0] CODE_BTN_TOOL_FINGER = 9'd325;
    localparam logic [CODE_W-1:0] CODE_BTN_TOUCH       = 9'd330;

    // event value sources
    typedef enum logic [3:0] {
        VAL_ZERO,
        VAL_ONE,
        VAL_NEG1,
        VAL_SLOT,
        VAL_ID,
        VAL_X,
        VAL_Y,
        VAL_MAJOR,
        VAL_MINOR
    } vsel_t;

    // jump conditions; a taken jump loads the target, otherwise pc + 1; a stalled step holds pc
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_IDLE,
        COND_SCAN_BUSY,
        COND_FULL,
        COND_UP,
        COND_NOT_CHANGE
    } cond_t;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_SCAN,
        UOP_CLAIM,
        UOP_RELEASE
    } uop_t;

    localparam int PC_W = 5;

    localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
    localparam logic [PC_W-1:0] PC_SCAN = 5'd1;
    localparam logic [PC_W-1:0] PC_POS  = 5'd9;
    localparam logic [PC_W-1:0] PC_UP   = 5'd14;
    localparam logic [PC_W-1:0] PC_FULL = 5'd18;

    typedef struct packed {
        logic              emit;
        evtype_t           ev_type;
        logic [CODE_W-1:0] ev_code;
        vsel_t             vsel;
        logic              last;
        logic              status;
        cond_t             cond;
        logic [PC_W-1:0]   target;
        uop_t              op;
    } ucw_t;

    function automatic ucw_t uc(input logic emit, input evtype_t t,
                                input logic [CODE_W-1:0] code, input vsel_t v,
                                input logic last, input logic st, input cond_t c,
                                input logic [PC_W-1:0] tgt, input uop_t op);
        ucw_t w;
        w.emit    = emit;
        w.ev_type = t;
        w.ev_code = code;
        w.vsel    = v;
        w.last    = last;
        w.status  = st;
        w.cond    = c;
        w.target  = tgt;
        w.op      = op;
        return w;
    endfunction

    // microprogram
    function automatic ucw_t uc_rom(input logic [PC_W-1:0] pc);
        ucw_t w;
        unique case (pc)
            5'd0:  w = uc(1'b0, EVT_SYN, CODE_SYN_RPT, VAL_ZERO, 1'b0, 1'b0,
                          COND_IDLE, PC_IDLE, UOP_LOAD);
            5'd1:  w = uc(1'b0, EVT_SYN, CODE_SYN_RPT, VAL_ZERO, 1'b0, 1'b0,
                          COND_SCAN_BUSY, PC_SCAN, UOP_SCAN);
            5'd2:  w = uc(1'b0, EVT_SYN, CODE_SYN_RPT, VAL_ZERO, 1'b0, 1'b0,
                          COND_FULL, PC_FULL, UOP_NOP);
            5'd3:  w = uc(1'b1, EVT_ABS, CODE_MT_SLOT, VAL_SLOT, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd4:  w = uc(1'b0, EVT_SYN, CODE_SYN_RPT, VAL_ZERO, 1'b0, 1'b0,
                          COND_UP, PC_UP, UOP_NOP);
            5'd5:  w = uc(1'b1, EVT_ABS, CODE_MT_TRACKING_ID, VAL_ID, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd6:  w = uc(1'b0, EVT_SYN, CODE_SYN_RPT, VAL_ZERO, 1'b0, 1'b0,
                          COND_NOT_CHANGE, PC_POS, UOP_NOP);
            5'd7:  w = uc(1'b1, EVT_KEY, CODE_BTN_TOUCH, VAL_ONE, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd8:  w = uc(1'b1, EVT_KEY, CODE_BTN_TOOL_FINGER, VAL_ONE, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd9:  w = uc(1'b1, EVT_ABS, CODE_MT_POSITION_X, VAL_X, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd10: w = uc(1'b1, EVT_ABS, CODE_MT_POSITION_Y, VAL_Y, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd11: w = uc(1'b1, EVT_ABS, CODE_MT_TOUCH_MAJOR, VAL_MAJOR, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd12: w = uc(1'b1, EVT_ABS, CODE_MT_TOUCH_MINOR, VAL_MINOR, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd13: w = uc(1'b1, EVT_SYN, CODE_SYN_RPT, VAL_ZERO, 1'b1, 1'b0,
                          COND_ALWAYS, PC_IDLE, UOP_CLAIM);
            5'd14: w = uc(1'b1, EVT_ABS, CODE_MT_TRACKING_ID, VAL_NEG1, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd15: w = uc(1'b1, EVT_KEY, CODE_BTN_TOUCH, VAL_ZERO, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd16: w = uc(1'b1, EVT_KEY, CODE_BTN_TOOL_FINGER, VAL_ZERO, 1'b0, 1'b0,
                          COND_NEXT, PC_IDLE, UOP_NOP);
            5'd17: w = uc(1'b1, EVT_SYN, CODE_SYN_RPT, VAL_ZERO, 1'b1, 1'b0,
                          COND_ALWAYS, PC_IDLE, UOP_RELEASE);
            5'd18: w = uc(1'b1, EVT_SYN, CODE_SYN_RPT, VAL_ZERO, 1'b1, 1'b1,
                          COND_ALWAYS, PC_IDLE, UOP_NOP);
            default: w = uc(1'b0, EVT_SYN, CODE_SYN_RPT, VAL_ZERO, 1'b0, 1'b0,
                            COND_ALWAYS, PC_IDLE, UOP_NOP);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/mtset_ram.sv
`default_nettype none
module mtset_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/multitouch_slot_event_translator_unit.sv
`default_nettype none
// Multitouch slot event translator. Each touch point request on the s_axis side
// (action up/down/change, finger id, x, y, contact major/minor) becomes a run of
// evdev multitouch type-B events on m_axis, one run per request, tlast on the
// closing SYN report: up gives 5 events, down 7, change 9. A known finger id maps
// to the slot it owns; otherwise the lowest free slot is used, claimed by a down
// or change and released again by an up. With no slot to give, a single SYN event
// with status 1 is sent and the table is untouched; action 3 is swallowed with no
// events. Control is a 19-step microprogram in a ROM; finger ids sit in a small
// RAM that is scanned one slot per cycle, and events wait while m_axis holds
// tready low. New requests are taken only in the idle step. Slot valid marks are
// cleared by reset, so no clearing pass is needed.
module multitouch_slot_event_translator_unit #(
    parameter int SLOT_COUNT = mtset_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] finger_id, [31:16] pos_x, [47:32] pos_y,
    // [63:48] contact_major, [79:64] contact_minor
    input  wire logic [mtset_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [1:0] action
    input  wire logic [mtset_pkg::S_USER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [8:0] event_code, [25:9] event_value (signed), [31:26] zero
    output logic      [mtset_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [1:0] evdev type, [2] status
    output logic      [mtset_pkg::M_USER_W-1:0] m_axis_tuser,
    // last_of_run
    output logic                                m_axis_tlast
);

    import mtset_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] SLOT_CNT  = CW'(SLOT_COUNT);

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    ucw_t            uw;
    logic            step_go;
    logic            taken;
    logic            s_accept;

    // point registers
    action_t            act_reg;
    logic [FIELD_W-1:0] id_reg, x_reg, y_reg, major_reg, minor_reg;

    // scan datapath
    logic [CW-1:0]      scan_idx_reg, scan_idx_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IW-1:0]      chk_idx_reg;
    logic               hit_reg, hit_next;
    logic               free_reg, free_next;
    logic [IW-1:0]      hit_slot_reg, hit_slot_next;
    logic [IW-1:0]      free_slot_reg, free_slot_next;
    logic               chk_last;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic [FIELD_W-1:0] rd_data;
    logic [IW-1:0]      sel_slot;
    logic               ram_we;

    logic [SLOT_COUNT-1:0] in_use_reg, in_use_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic [M_USER_W-1:0]   m_user_reg;
    logic                  m_last_reg;
    logic [VALUE_W-1:0]    ev_value;

    assign uw            = uc_rom(pc_reg);
    assign s_axis_tready = (pc_reg == PC_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign step_go       = !uw.emit || !m_valid_reg || m_axis_tready;
    assign chk_last      = chk_vld_reg && (chk_idx_reg == LAST_IDX);
    assign sel_slot      = hit_reg ? hit_slot_reg : free_slot_reg;

    always_comb
    begin
        unique case (uw.cond)
            COND_NEXT:       taken = 1'b0;
            COND_ALWAYS:     taken = 1'b1;
            COND_IDLE:       taken = !(s_accept && (s_axis_tuser != ACT_RSVD));
            COND_SCAN_BUSY:  taken = !chk_last;
            COND_FULL:       taken = !hit_reg && !free_reg;
            COND_UP:         taken = (act_reg == ACT_UP);
            COND_NOT_CHANGE: taken = (act_reg != ACT_CHANGE);
            default:         taken = 1'b1;
        endcase

        if (!step_go)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    // slot scan: address issued one cycle, owner compared the next
    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        chk_vld_next   = 1'b0;
        hit_next       = hit_reg;
        free_next      = free_reg;
        hit_slot_next  = hit_slot_reg;
        free_slot_next = free_slot_reg;
        in_use_next    = in_use_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_idx_reg[IW-1:0];
        ram_we         = 1'b0;

        case (uw.op)
            UOP_LOAD:
            begin
                scan_idx_next = '0;
                hit_next      = 1'b0;
                free_next     = 1'b0;
            end
            UOP_SCAN:
            begin
                if (scan_idx_reg < SLOT_CNT)
                begin
                    rd_en         = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                chk_vld_next = rd_en;
                if (chk_vld_reg)
                begin
                    if (in_use_reg[chk_idx_reg] && (rd_data == id_reg) && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = chk_idx_reg;
                    end
                    if (!in_use_reg[chk_idx_reg] && !free_reg)
                    begin
                        free_next      = 1'b1;
                        free_slot_next = chk_idx_reg;
                    end
                end
            end
            UOP_CLAIM:
            begin
                if (step_go && !hit_reg)
                begin
                    ram_we                = 1'b1;
                    in_use_next[sel_slot] = 1'b1;
                end
            end
            UOP_RELEASE:
            begin
                if (step_go)
                begin
                    in_use_next[sel_slot] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (uw.vsel)
            VAL_ZERO:  ev_value = '0;
            VAL_ONE:   ev_value = VALUE_W'(1);
            VAL_NEG1:  ev_value = '1;
            VAL_SLOT:  ev_value = VALUE_W'(sel_slot);
            VAL_ID:    ev_value = VALUE_W'(id_reg);
            VAL_X:     ev_value = VALUE_W'(x_reg);
            VAL_Y:     ev_value = VALUE_W'(y_reg);
            VAL_MAJOR: ev_value = VALUE_W'(major_reg);
            VAL_MINOR: ev_value = VALUE_W'(minor_reg);
            default:   ev_value = '0;
        endcase

        if (uw.emit && step_go)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= PC_IDLE;
            scan_idx_reg <= '0;
            chk_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            in_use_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            scan_idx_reg <= scan_idx_next;
            chk_vld_reg  <= chk_vld_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            in_use_reg   <= in_use_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if ((uw.op == UOP_LOAD) && s_accept)
        begin
            act_reg   <= action_t'(s_axis_tuser);
            id_reg    <= s_axis_tdata[15:0];
            x_reg     <= s_axis_tdata[31:16];
            y_reg     <= s_axis_tdata[47:32];
            major_reg <= s_axis_tdata[63:48];
            minor_reg <= s_axis_tdata[79:64];
        end
        chk_idx_reg   <= rd_addr;
        hit_slot_reg  <= hit_slot_next;
        free_slot_reg <= free_slot_next;
        if (uw.emit && step_go)
        begin
            m_data_reg <= {(M_DATA_W - VALUE_W - CODE_W)'(0), ev_value, uw.ev_code};
            m_user_reg <= {uw.status, uw.ev_type};
            m_last_reg <= uw.last;
        end
    end

    mtset_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_owner_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sel_slot),
        .wdata (id_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
`default_nettype wire

### hw/rtl/mtset_checker.sv
`default_nettype none
`include "assert_macros.svh"
module mtset_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [mtset_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  wire logic [mtset_pkg::S_USER_W-1:0] s_axis_tuser,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [mtset_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  wire logic [mtset_pkg::M_USER_W-1:0] m_axis_tuser,
    input  wire logic                           m_axis_tlast
);

    import mtset_pkg::*;

    logic                           s_go;
    logic                           m_stall;
    logic [M_USER_W+M_DATA_W:0]     m_beat;
    logic                           drop_beat;
    logic                           drop_ok;
    logic                           last_beat;
    logic                           syn_close;

    assign s_go      = s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_RSVD);
    assign m_stall   = m_axis_tvalid && !m_axis_tready;
    assign m_beat    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign drop_beat = m_axis_tvalid && m_axis_tuser[2];
    assign drop_ok   = m_axis_tlast && (m_axis_tuser[1:0] == EVT_SYN)
                       && (m_axis_tdata == '0);
    assign last_beat = m_axis_tvalid && m_axis_tlast;
    assign syn_close = (m_axis_tuser[1:0] == EVT_SYN)
                       && (m_axis_tdata[8:0] == CODE_SYN_RPT);

    // stalled event holds
    `ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid && $stable(m_beat), "stalled event changed")

    // a real point keeps the block busy for the slot scan
    `ASSERT_NEXT(a_busy_after_req, s_go, !s_axis_tready, "s_axis ready right after a request")

    // drop report is a bare closing SYN
    `ASSERT_PROP(a_drop_form, drop_beat |-> drop_ok, "malformed drop report")

    // every run closes with a SYN report
    `ASSERT_PROP(a_last_is_syn, last_beat |-> syn_close, "run does not end in a SYN report")

endmodule

bind multitouch_slot_event_translator_unit mtset_checker u_mtset_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### sim/touch_event_checker.sv
`default_nettype none
// Watches both stream sides of the slot event translator, keeps its own copy
// of the slot table, and checks every event against the expected run.
module touch_event_checker #(
    parameter int SLOT_COUNT = mtset_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [mtset_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  wire logic [mtset_pkg::S_USER_W-1:0] s_axis_tuser,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [mtset_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  wire logic [mtset_pkg::M_USER_W-1:0] m_axis_tuser,
    input  wire logic                           m_axis_tlast,
    output int                                  events_owed,
    output int                                  mismatch_count,
    output int                                  events_checked,
    output int                                  full_drops
);
    import mtset_pkg::*;

    localparam logic [VALUE_W-1:0] TRACKING_RELEASED = {VALUE_W{1'b1}};

    typedef struct packed {
        evtype_t             ev_type;
        logic [CODE_W-1:0]   code;
        logic [VALUE_W-1:0]  value;
        logic                last;
        logic                status;
    } touch_event_t;

    touch_event_t            owed_events[$];
    logic [FIELD_W-1:0]      owner_id[SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   slot_busy;

    task automatic add_event(input evtype_t t, input logic [CODE_W-1:0] c,
                             input logic [VALUE_W-1:0] v, input logic last,
                             input logic status);
        touch_event_t e;
        e.ev_type = t;
        e.code    = c;
        e.value   = v;
        e.last    = last;
        e.status  = status;
        owed_events.insert(owed_events.size(), e);
    endtask

    // One touch point in, its evdev run out; updates the slot table.
    task automatic translate_point(input action_t act, input logic [FIELD_W-1:0] id,
                                   input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                                   input logic [FIELD_W-1:0] maj,
                                   input logic [FIELD_W-1:0] mnr);
        int   slot;
        logic claim;
        slot  = -1;
        claim = 1'b0;
        if (act == ACT_RSVD)
            return;
        // owned slot first (lowest match), else lowest free one
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot < 0 && slot_busy[i] && owner_id[i] == id)
                slot = i;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot < 0 && !slot_busy[i]) begin
                slot  = i;
                claim = 1'b1;
            end
        if (slot < 0) begin
            add_event(EVT_SYN, CODE_SYN_RPT, '0, 1'b1, 1'b1);
            return;
        end
        add_event(EVT_ABS, CODE_MT_SLOT, VALUE_W'(slot), 1'b0, 1'b0);
        if (act == ACT_UP) begin
            add_event(EVT_ABS, CODE_MT_TRACKING_ID, TRACKING_RELEASED, 1'b0, 1'b0);
            add_event(EVT_KEY, CODE_BTN_TOUCH, '0, 1'b0, 1'b0);
            add_event(EVT_KEY, CODE_BTN_TOOL_FINGER, '0, 1'b0, 1'b0);
            add_event(EVT_SYN, CODE_SYN_RPT, '0, 1'b1, 1'b0);
            slot_busy[slot] = 1'b0;
            return;
        end
        if (claim) begin
            owner_id[slot]  = id;
            slot_busy[slot] = 1'b1;
        end
        add_event(EVT_ABS, CODE_MT_TRACKING_ID, VALUE_W'(id), 1'b0, 1'b0);
        if (act == ACT_CHANGE) begin
            add_event(EVT_KEY, CODE_BTN_TOUCH, VALUE_W'(1), 1'b0, 1'b0);
            add_event(EVT_KEY, CODE_BTN_TOOL_FINGER, VALUE_W'(1), 1'b0, 1'b0);
        end
        add_event(EVT_ABS, CODE_MT_POSITION_X, VALUE_W'(x), 1'b0, 1'b0);
        add_event(EVT_ABS, CODE_MT_POSITION_Y, VALUE_W'(y), 1'b0, 1'b0);
        add_event(EVT_ABS, CODE_MT_TOUCH_MAJOR, VALUE_W'(maj), 1'b0, 1'b0);
        add_event(EVT_ABS, CODE_MT_TOUCH_MINOR, VALUE_W'(mnr), 1'b0, 1'b0);
        add_event(EVT_SYN, CODE_SYN_RPT, '0, 1'b1, 1'b0);
    endtask

    task automatic compare_field(input string what, input int idx,
                                 input logic [31:0] want_v, input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: event %0d %s mismatch: expected %0h, actual %0h",
                     $time, idx, what, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Sampled at the edge: both sides see pre-edge values, so no ordering race.
    always @(posedge clk) begin : watch
        touch_event_t want;
        if (!rst_n) begin
            slot_busy      = '0;
            owed_events.delete();
            mismatch_count = 0;
            events_checked = 0;
            full_drops     = 0;
            events_owed   <= 0;
        end else begin
            // outputs first: an event at this edge can only belong to an older point
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_events.size() == 0) begin
                    $display("%0t: unexpected event: expected none, actual type %0h code %0h",
                             $time, m_axis_tuser[1:0], m_axis_tdata[CODE_W-1:0]);
                    mismatch_count++;
                end else begin
                    want = owed_events.pop_front();
                    compare_field("type", events_checked, 32'(want.ev_type),
                                  32'(m_axis_tuser[1:0]));
                    compare_field("code", events_checked, 32'(want.code),
                                  32'(m_axis_tdata[CODE_W-1:0]));
                    compare_field("value", events_checked, 32'(want.value),
                                  32'(m_axis_tdata[CODE_W +: VALUE_W]));
                    compare_field("pad", events_checked, 32'd0,
                                  32'(m_axis_tdata[M_DATA_W-1:CODE_W+VALUE_W]));
                    compare_field("last", events_checked, 32'(want.last),
                                  32'(m_axis_tlast));
                    compare_field("status", events_checked, 32'(want.status),
                                  32'(m_axis_tuser[2]));
                    if (want.status)
                        full_drops++;
                    events_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                translate_point(action_t'(s_axis_tuser), s_axis_tdata[15:0],
                                s_axis_tdata[31:16], s_axis_tdata[47:32],
                                s_axis_tdata[63:48], s_axis_tdata[79:64]);
            events_owed <= owed_events.size();
        end
    end

endmodule
`default_nettype wire

### sim/tb_multitouch_slot_event_translator_unit.sv
`default_nettype none
// Stimulus and verdict for the slot event translator. Event checks live in
// touch_event_checker and the bound mtset_checker; this module drives requests and pulls events.
module tb_multitouch_slot_event_translator_unit;
    import mtset_pkg::*;

    // The cycle limit covers every point at its slowest legal pace, with idle gaps,
    // the slot scan and receiver stalls, plus the long hold.
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RANDOM_POINTS  = 430;
    localparam int POOL_SIZE      = 20;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES    = SLOT_COUNT_DEF + 24;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [S_USER_W-1:0] s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;
    logic                m_axis_tlast;

    int events_owed;
    int mismatch_count;
    int events_checked;
    int full_drops;

    int cycle_count  = 0;
    int points_sent  = 0;     // every accepted request, action 3 included
    int points_noop  = 0;     // action-3 requests the block swallows
    bit no_idle      = 1'b0;  // both sides run flat out
    bit rx_hold_req  = 1'b0;  // ask the receiver for its long hold-off
    bit rx_hold_done = 1'b0;

    logic [FIELD_W-1:0] finger_pool[POOL_SIZE];

    always #1 clk = ~clk;

    multitouch_slot_event_translator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    touch_event_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .events_owed    (events_owed),
        .mismatch_count (mismatch_count),
        .events_checked (events_checked),
        .full_drops     (full_drops)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events still owed",
                     cycle_count, events_owed);
            $display("simulation failed");
            $finish;
        end
    end

    // Coordinates: mostly full-range random, with the two extremes mixed in.
    function automatic logic [FIELD_W-1:0] rand_coord();
        logic [FIELD_W-1:0] v;
        v = FIELD_W'($urandom);
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // Present one point and hold it until the request is taken. A zero gap
    // keeps tvalid high across points, so tvalid sees one assignment per step.
    task automatic offer_point(input action_t act, input logic [FIELD_W-1:0] id,
                               input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                               input logic [FIELD_W-1:0] maj,
                               input logic [FIELD_W-1:0] mnr);
        int gap;
        gap = (no_idle || (rx_hold_req && !rx_hold_done)) ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {mnr, maj, y, x, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        points_sent++;
        if (act == ACT_RSVD)
            points_noop++;
    endtask

    // Wait until every owed event has come back. The first edge lets the
    // checker count a request taken at the edge we were called on.
    task automatic drain_events();
        @(posedge clk);
        while (events_owed != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall before each event, one long hold-off on request,
    // and no stalls at all during the flat-out stretch.
    initial begin : event_sink
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (no_idle)
                stall = 0;
            else if ($urandom_range(0, 2) == 0)
                stall = 0;
            else
                stall = $urandom_range(0, 14);
            if (rx_hold_req && !rx_hold_done)
                stall = RX_HOLD_CYCLES;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                if (rx_hold_req)
                    rx_hold_done = 1'b1;
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
        end
    end

    initial begin : point_source
        logic [FIELD_W-1:0] fid;
        action_t            act;
        int                 pick;
        int                 random_points;
        bit                 paused;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_UP;
        random_points = 0;
        paused        = 1'b0;
        // ids 0x0000, 0x1111 ... 0xFFFF cover every id bit both ways
        for (int i = 0; i < POOL_SIZE; i++)
            finger_pool[i] = (i < 16) ? FIELD_W'(i * 16'h1111) : FIELD_W'($urandom);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // down and change at the field extremes on slot 0
        offer_point(ACT_DOWN, 16'h0000, '0, '0, '0, '0);
        offer_point(ACT_CHANGE, 16'h0000, '1, '1, '1, '1);
        // up for a finger that owns nothing: borrows slot 1, table unchanged
        offer_point(ACT_UP, 16'hFFFF, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        // unused action: swallowed
        offer_point(ACT_RSVD, 16'h0000, '1, '1, '1, '1);
        // fill slots 1..15
        for (int k = 1; k < 16; k++) begin
            fid = FIELD_W'(k * 16'h1111);
            offer_point(ACT_DOWN, fid, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
        // table full: new down, stray up and new change are all dropped
        offer_point(ACT_DOWN, 16'hABCD, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        offer_point(ACT_UP, 16'h1234, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        offer_point(ACT_CHANGE, 16'h2468, rand_coord(), rand_coord(), rand_coord(),
                    rand_coord());
        // free slot 5 and claim it again with the id that was refused
        offer_point(ACT_UP, 16'h5555, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        offer_point(ACT_DOWN, 16'hABCD, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        offer_point(ACT_UP, 16'h0000, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        s_axis_tvalid <= 1'b0;
        drain_events();

        // ---- random part ----
        // Fingers come from a pool a bit larger than the table, so runs of
        // down/change/up on the same id dominate and the table fills now and then.
        while (random_points < RANDOM_POINTS) begin
            if (random_points == 120)
                rx_hold_req = 1'b1;
            no_idle = (random_points >= 330 && random_points < 380);
            if (random_points == 260 && !paused) begin
                // sender goes quiet until every owed event is out
                s_axis_tvalid <= 1'b0;
                drain_events();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
                act = ACT_RSVD;
            else if (pick < 32)
                act = ACT_DOWN;
            else if (pick < 60)
                act = ACT_CHANGE;
            else
                act = ACT_UP;
            // stray ids only on up, so they never pin slots for good
            if (act == ACT_UP && $urandom_range(0, 9) == 0)
                fid = FIELD_W'($urandom);
            else
                fid = finger_pool[$urandom_range(0, POOL_SIZE - 1)];
            offer_point(act, fid, rand_coord(), rand_coord(), rand_coord(), rand_coord());
            if (act != ACT_RSVD)
                random_points++;
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        drain_events();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d touch points (%0d unused action), checked %0d events",
                 points_sent, points_noop, events_checked);
        $display("%0d points dropped on a full table, long receiver hold and sender pause done",
                 full_drops);
        if (mismatch_count == 0 && events_owed == 0) begin
            $display("simulation ok");
        end else begin
            if (events_owed != 0)
                $display("%0d expected events never arrived", events_owed);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### multitouch_slot_event_translator_unit.f
+incdir+hw/rtl
hw/rtl/mtset_pkg.sv
hw/rtl/mtset_ram.sv
hw/rtl/multitouch_slot_event_translator_unit.sv
hw/rtl/mtset_checker.sv
sim/touch_event_checker.sv
sim/tb_multitouch_slot_event_translator_unit.sv
